[design/olmd_pkg.sv]
// Package for the opcode/length message deframer.
// Holds buffer sizing, opcode class constants, checksum and slot constants, config register indexes and the state type.
`default_nettype none
package olmd_pkg;
	localparam int unsigned BUF_DEPTH = 64;
	localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
	localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
	localparam logic [7:0] CLS_MASK = 8'hE0;
	localparam logic [7:0] CLS_2 = 8'h80;
	localparam logic [7:0] CLS_4 = 8'hA0;
	localparam logic [7:0] CLS_6 = 8'hC0;
	localparam logic [7:0] CLS_VAR = 8'hE0;
	localparam logic [7:0] SUM_INIT = 8'hFF;
	localparam logic [7:0] SLOT_LEN = 8'd14;
	localparam logic REG_SLOT_WR = 1'b0;
	localparam logic REG_SLOT_RD = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_HEAD = 7'b0000010,
		ST_LEN  = 7'b0000100,
		ST_DEC  = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_EMIT = 7'b0100000,
		ST_DROP = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

[design/opcode_length_message_deframer.sv]
// Opcode/length message deframer: sequencer over a circular byte store.
// Depends on olmd_pkg and olmd_store.
// An accepted byte holds s_tready low until the sequencer is back in idle, and each head byte
// dropped adds a further pass; a message whose checksum fails drops its head byte and the
// search restarts at the next byte. Emission stalls while m_tready is low.
// Reset empties the store.
`default_nettype none
module opcode_length_message_deframer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // msg_byte[7:0], msg_first, msg_length[6:0]
	output logic        m_tlast    // msg_last
);
	import olmd_pkg::*;

	state_t state_q;
	logic [7:0] slot_wr_q, slot_rd_q;
	logic [PTR_W-1:0] head_q, idx_q;
	logic [CNT_W-1:0] fill_q;
	logic [7:0] len_q, sum_q;
	logic rd_pend_q, emit_first_q;
	logic [PTR_W-1:0] raddr;
	logic [7:0] rdata;
	logic st_we;
	logic [PTR_W-1:0] st_waddr;
	logic [CNT_W-1:0] fill_inc;
	logic [CNT_W:0] len_ext;
	logic out_free;
	logic emit_fire;

	assign s_tready = (state_q == ST_IDLE);
	assign st_we = s_tvalid && s_tready;
	assign st_waddr = head_q + fill_q[PTR_W-1:0];
	assign fill_inc = fill_q + CNT_W'(1);
	assign len_ext = {{(CNT_W+1-8){1'b0}}, len_q};
	assign out_free = !m_tvalid || m_tready;
	assign emit_fire = (state_q == ST_EMIT) && rd_pend_q && out_free;

	always_comb begin
		raddr = head_q + idx_q;
	end

	olmd_store u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(s_tdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_wr_q <= 8'hEF;
			slot_rd_q <= 8'hE7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_WR: slot_wr_q <= cfg_data;
				REG_SLOT_RD: slot_rd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			fill_q <= '0;
			idx_q <= '0;
			len_q <= '0;
			sum_q <= '0;
			rd_pend_q <= 1'b0;
			emit_first_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (emit_fire) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (st_we) begin
						if (fill_inc >= CNT_W'(BUF_DEPTH)) begin
							fill_q <= '0;
						end else begin
							fill_q <= fill_inc;
							idx_q <= '0;
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					// Read of the head byte is issued; data lands next cycle.
					idx_q <= PTR_W'(1);
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_DEC;
					priority if ((rdata & CLS_MASK) == CLS_2) len_q <= 8'd2;
					else if ((rdata & CLS_MASK) == CLS_4) len_q <= 8'd4;
					else if ((rdata & CLS_MASK) == CLS_6) len_q <= 8'd6;
					else if ((rdata & CLS_MASK) == CLS_VAR) begin
						if (rdata == slot_wr_q || rdata == slot_rd_q) begin
							len_q <= SLOT_LEN;
						end else if (fill_q < CNT_W'(2)) begin
							state_q <= ST_IDLE;
						end else begin
							len_q <= 8'd0;
							rd_pend_q <= 1'b1;
						end
					end else begin
						state_q <= ST_DROP;
					end
				end
				ST_DEC: begin
					if (rd_pend_q) begin
						len_q <= rdata;
						rd_pend_q <= 1'b0;
					end else if (len_q < 8'd2 || len_ext > (CNT_W+1)'(BUF_DEPTH)) begin
						state_q <= ST_DROP;
					end else if ({1'b0, fill_q} < len_ext) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= '0;
						sum_q <= SUM_INIT;
						rd_pend_q <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// rd_pend_q marks that rdata holds byte idx_q-1.
					if (rd_pend_q) begin
						sum_q <= sum_q ^ rdata;
					end
					rd_pend_q <= 1'b1;
					if (rd_pend_q && {1'b0, idx_q} == len_q[PTR_W:0]) begin
						if ((sum_q ^ rdata) == 8'd0) begin
							idx_q <= '0;
							rd_pend_q <= 1'b0;
							emit_first_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DROP;
						end
					end else if ({1'b0, idx_q} != len_q[PTR_W:0]) begin
						idx_q <= idx_q + PTR_W'(1);
					end
				end
				ST_EMIT: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (out_free) begin
						m_tdata <= {len_q[6:0], emit_first_q, rdata};
						m_tlast <= ({1'b0, idx_q} == len_q[PTR_W:0] - (PTR_W+1)'(1));
						emit_first_q <= 1'b0;
						rd_pend_q <= 1'b0;
						if ({1'b0, idx_q} == len_q[PTR_W:0] - (PTR_W+1)'(1)) begin
							head_q <= head_q + len_q[PTR_W-1:0];
							fill_q <= fill_q - len_ext[CNT_W-1:0];
							idx_q <= '0;
							state_q <= (fill_q == len_ext[CNT_W-1:0]) ? ST_IDLE : ST_HEAD;
						end else begin
							idx_q <= idx_q + PTR_W'(1);
						end
					end
				end
				ST_DROP: begin
					head_q <= head_q + PTR_W'(1);
					fill_q <= fill_q - CNT_W'(1);
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					state_q <= (fill_q == CNT_W'(1)) ? ST_IDLE : ST_HEAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(BUF_DEPTH)) else $error("fill count reached depth");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output changed while stalled");
`endif
endmodule
`default_nettype wire

[design/olmd_store.sv]
// Byte store of the deframer: a memory with one write port and one registered read port.
// Depends on olmd_pkg.
`default_nettype none
module olmd_store (
	input  wire                      clk,
	input  wire                      we,
	input  wire [olmd_pkg::PTR_W-1:0] waddr,
	input  wire [7:0]                wdata,
	input  wire [olmd_pkg::PTR_W-1:0] raddr,
	output logic [7:0]               rdata
);
	import olmd_pkg::*;
	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
